FILE: design/prf_pkg.sv
// Shared constants and types for the Pollard rho factor unit.
// No dependencies; imported by prf_engine and pollard_rho_factor_unit.
`default_nettype none

package prf_pkg;

  localparam int WIDTH       = 32;
  localparam int CNT_W       = $clog2(WIDTH);
  localparam int IN_TDATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WIDTH + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WIDTH - 1);
  localparam logic [WIDTH-1:0] SEED      = WIDTH'(2);
  localparam logic [WIDTH-1:0] EVEN_ANS  = WIDTH'(2);
  localparam logic [WIDTH-1:0] ONE       = WIDTH'(1);

  // engine status toward the stream wrapper
  typedef struct packed {
    logic busy;
    logic done;
  } prf_stat_t;

endpackage

`default_nettype wire

FILE: design/prf_engine.sv
// Sequencer and shared subtractor for the rho walk: c mod n, modular
// squaring by shift-and-add, and binary gcd. Depends on prf_pkg.
`default_nettype none

module prf_engine
  import prf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] n_i,
  input  wire logic [WIDTH-1:0] c_i,
  input  wire logic             ack,
  output prf_stat_t             stat,
  output logic      [WIDTH-1:0] result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMOD  = 3'd1;
  localparam logic [2:0] S_SQADD = 3'd2;
  localparam logic [2:0] S_SQDBL = 3'd3;
  localparam logic [2:0] S_ADDC  = 3'd4;
  localparam logic [2:0] S_GABS  = 3'd5;
  localparam logic [2:0] S_GCD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;
  logic [WIDTH-1:0] c_r, c_nxt;
  logic [WIDTH-1:0] cm_r, cm_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] ga_r, ga_nxt;
  logic [WIDTH-1:0] gb_r, gb_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;

  // the one shared subtract/compare unit
  logic [WIDTH:0]   sub_l, sub_r;
  logic [WIDTH+1:0] sub_d;
  logic             borrow;
  logic [WIDTH-1:0] red;      // sub_l reduced by one conditional subtract
  logic [WIDTH-1:0] absd;
  logic [WIDTH:0]   sum_acc, sum_c;

  assign sub_d   = {1'b0, sub_l} - {1'b0, sub_r};
  assign borrow  = sub_d[WIDTH+1];
  assign red     = borrow ? sub_l[WIDTH-1:0] : sub_d[WIDTH-1:0];
  assign absd    = borrow ? (~sub_d[WIDTH-1:0]) + ONE : sub_d[WIDTH-1:0];
  assign sum_acc = {1'b0, acc_r} + {1'b0, a_r};
  assign sum_c   = {1'b0, acc_r} + {1'b0, cm_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    n_nxt     = n_r;
    c_nxt     = c_r;
    cm_nxt    = cm_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    ga_nxt    = ga_r;
    gb_nxt    = gb_r;
    res_nxt   = res_r;
    sub_l     = {1'b0, ga_r};
    sub_r     = {1'b0, gb_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt   = n_i;
          c_nxt   = c_i;
          cnt_nxt = '0;
          acc_nxt = '0;
          if (!n_i[0]) begin
            res_nxt   = EVEN_ANS;
            state_nxt = S_DONE;
          end else if (n_i == ONE) begin
            res_nxt   = ONE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CMOD;
          end
        end
      end

      // restoring reduction of c, one bit of c per cycle
      S_CMOD: begin
        sub_l   = {acc_r, c_r[WIDTH-1]};
        sub_r   = {1'b0, n_r};
        acc_nxt = red;
        c_nxt   = c_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cm_nxt    = red;
          x_nxt     = SEED;
          y_nxt     = SEED;
          a_nxt     = SEED;
          b_nxt     = SEED;
          acc_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQADD;
        end
      end

      S_SQADD: begin
        sub_l = sum_acc;
        sub_r = {1'b0, n_r};
        if (b_r[0]) acc_nxt = red;
        state_nxt = S_SQDBL;
      end

      S_SQDBL: begin
        sub_l   = {a_r, 1'b0};
        sub_r   = {1'b0, n_r};
        a_nxt   = red;
        b_nxt   = b_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ADDC;
        end else begin
          state_nxt = S_SQADD;
        end
      end

      // v*v mod n + c mod n; next operand to square, or on to the gcd
      S_ADDC: begin
        sub_l   = sum_c;
        sub_r   = {1'b0, n_r};
        acc_nxt = '0;
        cnt_nxt = '0;
        case (step_r)
          2'd0: begin
            x_nxt     = red;
            a_nxt     = y_r;
            b_nxt     = y_r;
            step_nxt  = 2'd1;
            state_nxt = S_SQADD;
          end
          2'd1: begin
            y_nxt     = red;
            a_nxt     = red;
            b_nxt     = red;
            step_nxt  = 2'd2;
            state_nxt = S_SQADD;
          end
          default: begin
            y_nxt     = red;
            state_nxt = S_GABS;
          end
        endcase
      end

      S_GABS: begin
        sub_l     = {1'b0, x_r};
        sub_r     = {1'b0, y_r};
        ga_nxt    = absd;
        gb_nxt    = n_r;
        state_nxt = S_GCD;
      end

      // binary gcd; gb stays odd throughout
      S_GCD: begin
        if (ga_r == '0) begin
          if (gb_r == ONE) begin
            a_nxt     = x_r;
            b_nxt     = x_r;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_SQADD;
          end else begin
            res_nxt   = gb_r;
            state_nxt = S_DONE;
          end
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!borrow) begin
          ga_nxt = sub_d[WIDTH:1];
        end else begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end
      end

      S_DONE: begin
        if (ack) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    c_r   <= c_nxt;
    cm_r  <= cm_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    ga_r  <= ga_nxt;
    gb_r  <= gb_nxt;
    res_r <= res_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign result    = res_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("start while engine busy");

  a_gcd_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> gb_r[0])
    else $error("gcd operand lost oddness");

  a_res_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> res_r != '0)
    else $error("zero factor");

  a_walk_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQADD || state_r == S_SQDBL) |-> (acc_r < n_r && a_r < n_r))
    else $error("squaring operand not reduced");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !ack) |=> (state_r == S_DONE && $stable(res_r)))
    else $error("result dropped before handoff");
`endif

endmodule

`default_nettype wire

FILE: design/pollard_rho_factor_unit.sv
// Pollard rho factor unit (Floyd cycle detection), stream wrapper.
// Uses prf_pkg and prf_engine.
//
// Usage:
//   Input beat: in_tdata carries n (bits 31:0) and c (bits 63:32). The
//   beat is taken when in_tvalid and in_tready are both high. in_tready
//   is high whenever the engine is idle, also while a result waits.
//   Output beat: out_tdata carries the factor found: 2 for even n, 1 for
//   n of one, n when the walk fails to split n, else a proper divisor.
//   Work: even n and n of one are answered without a walk. Otherwise c
//   is reduced mod n, then each round does three squarings by
//   shift-and-add on the shared subtractor, the difference, and a binary
//   gcd. The round count depends on the data, near the fourth root of n.
//   One item is worked at a time; the output register hands the result
//   over, and the engine holds a finished result while that register is
//   full and out_tready is low. Reset clears the sequencer and the output
//   valid; no state is kept between items.
`default_nettype none

module pollard_rho_factor_unit
  import prf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // n, c
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // factor
);

  prf_stat_t        stat;
  logic [WIDTH-1:0] result;
  logic             in_beat;
  logic             load;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign in_tready = !stat.busy;
  assign in_beat   = in_tvalid && in_tready;
  assign load      = stat.done && (!out_tvalid_r || out_tready);

  prf_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_beat),
    .n_i    (in_tdata[WIDTH-1:0]),
    .c_i    (in_tdata[2*WIDTH-1:WIDTH]),
    .ack    (load),
    .stat   (stat),
    .result (result)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    if (load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_TDATA_W'(result);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> $stable(out_tdata_r))
    else $error("pending result overwritten");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("accepted beat did not occupy engine");

  a_factor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_tdata_r != '0)
    else $error("zero factor on output");
`endif

endmodule

`default_nettype wire
